FILE: hdl/rsoq_pkg.sv
// Shared types and constants for the rotational seek order queue.
// Used by the front, back and top-level modules; depends on nothing.
package rsoq_pkg;

  localparam int CFG_W = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CFG_NUM_SECTORS = 2'd0,
    CFG_TIME_PER_SECTOR = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_HEAD,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CLS_INSERT,
    CLS_REMOVE,
    CLS_QUERY
  } cls_t;

endpackage

FILE: hdl/rotational_seek_order_queue.sv
// Top level of the rotational seek order queue.
// Instantiates rsoq_front and rsoq_back; depends on rsoq_pkg.
//
// The queue keeps up to QUEUE_DEPTH disk requests sorted by rotational
// distance from the current head sector, and answers every input word
// with one result word describing the head after the operation. A front
// stage accepts words into a two-word command queue, and the back stage
// takes a registered word from that queue when it is idle, working one
// command at a time. A remove or query passes through the head, multiply
// and output states. An insert into a queue that is not full scans from
// the head until it meets a larger distance, or reaches the tail, and then
// shifts the tail one slot per cycle before the head, multiply and output
// states. The result word holds in the output register until taken, while
// the front keeps accepting. The user must write configuration only while
// idle; the block itself does not enforce this.
module rotational_seek_order_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  process_id,
  input  logic [7:0]  request_id,
  input  logic        op_kind,
  input  logic [15:0] target_sector,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  queue_count,
  output logic        head_valid,
  output logic [7:0]  head_process_id,
  output logic [7:0]  head_request_id,
  output logic        head_op_kind,
  output logic [31:0] head_wait_time,
  output logic [1:0]  error_code
);
  import rsoq_pkg::*;

  localparam int CMD_W = 2 + 8 + 8 + 1 + SECTOR_BITS;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [15:0] num_sectors;
  logic [15:0] time_per_sector;
  logic cmd_valid, cmd_pop;
  logic [CMD_W-1:0] cmd_data;
  logic [CNT_W-1:0] cnt;

  // Register writes; index 0 sets the sector count, any other the time per sector.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_sectors <= 16'd1;
      time_per_sector <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_NUM_SECTORS)) num_sectors <= cfg_data;
      else time_per_sector <= cfg_data;
    end
  end

  rsoq_front #(.SECTOR_BITS(SECTOR_BITS), .CMD_W(CMD_W)) u_front (
    .clk, .rst, .in_valid, .in_stall,
    .in_op(operation), .in_pid(process_id), .in_req(request_id),
    .in_kind(op_kind), .in_sector(target_sector),
    .cmd_valid, .cmd_pop, .cmd_data
  );

  rsoq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .SECTOR_BITS(SECTOR_BITS), .CMD_W(CMD_W)) u_back (
    .clk, .rst, .num_sectors, .time_per_sector,
    .cmd_valid, .cmd_pop, .cmd_data, .out_valid, .out_stall,
    .count_o(cnt), .head_valid_o(head_valid), .head_pid_o(head_process_id),
    .head_req_o(head_request_id), .head_kind_o(head_op_kind),
    .wait_o(head_wait_time), .err_o(error_code)
  );

  assign queue_count = 6'(cnt);
endmodule

FILE: hdl/rsoq_front.sv
// Front end: accepts input words, classifies the operation and pushes
// them into a two-entry command queue. Depends on rsoq_pkg.
module rsoq_front #(
  parameter int SECTOR_BITS = 16,
  parameter int CMD_W = 2 + 8 + 8 + 1 + 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_op,
  input  logic [7:0]             in_pid,
  input  logic [7:0]             in_req,
  input  logic                   in_kind,
  input  logic [15:0]            in_sector,
  output logic                   cmd_valid,
  input  logic                   cmd_pop,
  output logic [CMD_W-1:0]       cmd_data
);
  import rsoq_pkg::*;

  logic [CMD_W-1:0] fifo [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic [1:0]       cls;
  logic [SECTOR_BITS-1:0] sec;
  logic             push;

  always_comb begin
    case (in_op)
      OP_INSERT: cls = CLS_INSERT;
      OP_REMOVE: cls = CLS_REMOVE;
      default:   cls = CLS_QUERY;
    endcase
  end

  // Sector masked to the configured width.
  assign sec = SECTOR_BITS'(in_sector);
  assign in_stall = (fill == 2'd2);
  assign push = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd_data = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= {cls, in_pid, in_req, in_kind, sec};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(cmd_pop);
    end
  end
endmodule

FILE: hdl/rsoq_back.sv
// Back end: holds the ordered request slots, runs the distance scan and
// shift, and forms one result word per command. Depends on rsoq_pkg.
module rsoq_back #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SECTOR_BITS = 16,
  parameter int CMD_W = 35,
  parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      num_sectors,
  input  logic [15:0]      time_per_sector,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] count_o,
  output logic             head_valid_o,
  output logic [7:0]       head_pid_o,
  output logic [7:0]       head_req_o,
  output logic             head_kind_o,
  output logic [31:0]      wait_o,
  output logic [1:0]       err_o
);
  import rsoq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int SLOT_W = 17 + SECTOR_BITS;
  localparam int DW = SECTOR_BITS + 1;

  logic [SLOT_W-1:0] slots [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count;
  logic [SECTOR_BITS-1:0] head_pos;
  state_t state, state_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  pos;
  logic [SLOT_W-1:0] new_slot;
  logic [DW-1:0]     dnew;
  logic [DW-1:0]     dist_r;
  logic [1:0]        err;
  logic [SLOT_W-1:0] rd;
  logic              found;

  // Rotational distance from the head, raised to at least one.
  function automatic logic [DW-1:0] rot_dist(input logic [SECTOR_BITS-1:0] t,
                                             input logic [SECTOR_BITS-1:0] c,
                                             input logic [15:0] n);
    logic signed [DW+1:0] d;
    d = $signed({2'b00, t}) - $signed({2'b00, c});
    if (d <= 0) d = d + $signed((DW+2)'(n));
    if (d < 1) d = 1;
    return d[DW-1:0];
  endfunction

  assign rd = slots[idx[IDX_W-1:0]];
  assign found = rot_dist(rd[SECTOR_BITS-1:0], head_pos, num_sectors) > dnew;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd_valid) state_next = (cls_t'(cmd_data[CMD_W-1 -: 2]) == CLS_INSERT &&
                                          count != CNT_W'(QUEUE_DEPTH)) ? ST_SCAN : ST_HEAD;
      ST_SCAN:  if (idx >= count || found) state_next = ST_SHIFT;
      ST_SHIFT: if (idx <= pos) state_next = ST_HEAD;
      ST_HEAD:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_OUT;
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid;
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        new_slot <= cmd_data[SLOT_W-1:0];
        dnew <= rot_dist(cmd_data[SECTOR_BITS-1:0], head_pos, num_sectors);
        idx <= '0;
        err <= ERR_OK;
        if (cmd_valid) begin
          if (cls_t'(cmd_data[CMD_W-1 -: 2]) == CLS_INSERT &&
              count == CNT_W'(QUEUE_DEPTH)) err <= ERR_FULL;
          if (cls_t'(cmd_data[CMD_W-1 -: 2]) == CLS_REMOVE) begin
            if (count == '0) err <= ERR_EMPTY;
            else begin
              head_pos <= slots[0][SECTOR_BITS-1:0];
              for (int i = 0; i < QUEUE_DEPTH - 1; i++) slots[i] <= slots[i+1];
              count <= count - 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (idx >= count || found) begin
          pos <= idx;
          idx <= count;
        end else idx <= idx + 1'b1;
      end
      ST_SHIFT: begin
        if (idx <= pos) begin
          slots[pos[IDX_W-1:0]] <= new_slot;
          count <= count + 1'b1;
        end else begin
          slots[idx[IDX_W-1:0]] <= slots[idx[IDX_W-1:0] - 1'b1];
          idx <= idx - 1'b1;
        end
      end
      ST_HEAD: dist_r <= rot_dist(slots[0][SECTOR_BITS-1:0], head_pos, num_sectors);
      ST_MUL: begin
        count_o <= count;
        head_valid_o <= (count != '0);
        head_pid_o <= (count != '0) ? slots[0][SLOT_W-1 -: 8] : 8'd0;
        head_req_o <= (count != '0) ? slots[0][SLOT_W-9 -: 8] : 8'd0;
        head_kind_o <= (count != '0) ? slots[0][SECTOR_BITS] : 1'b0;
        wait_o <= (count != '0) ? 32'(32'(time_per_sector) * 32'(dist_r)) : 32'd0;
        err_o <= err;
      end
      default: ;
    endcase
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      head_pos <= '0;
    end else state <= state_next;
  end
endmodule

FILE: hdl/rsoq_checker.sv
// Port-level checks for the rotational seek order queue, with the bind
// that attaches them to the top level. Depends on rsoq_pkg.
module rsoq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  queue_count,
  input logic        head_valid,
  input logic [31:0] head_wait_time,
  input logic [1:0]  error_code
);
  import rsoq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(queue_count))
    else $error("stalled result changed");
  a_head: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> head_valid == (queue_count != 6'd0))
    else $error("head_valid disagrees with count");
  a_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> head_wait_time == 32'd0)
    else $error("wait time reported for an empty queue");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_EMPTY |-> queue_count == 6'd0)
    else $error("empty error with nonzero count");
endmodule

bind rotational_seek_order_queue rsoq_checker u_rsoq_checker (
  .clk, .rst, .out_valid, .out_stall, .queue_count, .head_valid,
  .head_wait_time, .error_code
);
